// File: rtl/ftws_pkg.sv
package ftws_pkg;

   localparam int SMP_W     = 24;
   localparam int RATE_W    = 28;
   localparam int SQ_W      = 32;
   localparam int DIV_W     = 36;
   localparam int DVS_W     = 32;
   localparam int DIV_STEPS = DIV_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int UPC_W     = 4;

   localparam int D10_W     = 18;
   localparam int D10_STEPS = 2;
   localparam int D10_SHIFT = 39;
   localparam int PROD_W    = DIV_W + 2 * D10_W;

   localparam logic [DIV_W-1:0]  RATE_NUM   = 36'd65536000000;
   localparam logic [RATE_W-1:0] RATE_MAX   = 28'hFFFFFFF;
   localparam logic [D10_W-1:0]  D10_MUL_LO = 18'h0CCCD;
   localparam logic [D10_W-1:0]  D10_MUL_HI = 18'h33333;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SLOT,
      RD_WALK
   } rd_sel_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_EMA,
      DIV_RATE,
      DIV_MEAN
   } div_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_EMA,
      CAP_RATE,
      CAP_OUT
   } cap_type;

   typedef enum logic [2:0] {
      CND_GO,
      CND_REQ,
      CND_DIV,
      CND_WALK,
      CND_OUT
   } cond_type;

   typedef struct packed {
      rd_sel_type        rd;
      logic              upd;
      div_sel_type       div;
      cap_type           cap;
      cond_type          cond;
      logic [UPC_W-1:0]  nxt;
   } uword_type;

   typedef struct packed {
      logic req_fire;
      logic div_busy;
      logic walk_more;
      logic out_free;
   } seq_stat_type;

   localparam logic [UPC_W-1:0] UA_IDLE  = 4'd0;
   localparam logic [UPC_W-1:0] UA_EVICT = 4'd1;
   localparam logic [UPC_W-1:0] UA_UPD   = 4'd2;
   localparam logic [UPC_W-1:0] UA_EMAW  = 4'd3;
   localparam logic [UPC_W-1:0] UA_RATE  = 4'd4;
   localparam logic [UPC_W-1:0] UA_RATEW = 4'd5;
   localparam logic [UPC_W-1:0] UA_MEAN  = 4'd6;
   localparam logic [UPC_W-1:0] UA_WALK  = 4'd7;
   localparam logic [UPC_W-1:0] UA_MEANW = 4'd8;
   localparam logic [UPC_W-1:0] UA_OUT   = 4'd9;

   function automatic uword_type ucode(input logic [UPC_W-1:0] addr);
      uword_type w;
      case (addr)
         UA_IDLE:  w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_REQ, nxt: UA_EVICT};
         UA_EVICT: w = '{rd: RD_SLOT, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_GO, nxt: UA_UPD};
         UA_UPD:   w = '{rd: RD_NONE, upd: 1'b1, div: DIV_EMA, cap: CAP_NONE,
                         cond: CND_GO, nxt: UA_EMAW};
         UA_EMAW:  w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_DIV, nxt: UA_RATE};
         UA_RATE:  w = '{rd: RD_NONE, upd: 1'b0, div: DIV_RATE, cap: CAP_EMA,
                         cond: CND_GO, nxt: UA_RATEW};
         UA_RATEW: w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_DIV, nxt: UA_MEAN};
         UA_MEAN:  w = '{rd: RD_NONE, upd: 1'b0, div: DIV_MEAN, cap: CAP_RATE,
                         cond: CND_GO, nxt: UA_WALK};
         UA_WALK:  w = '{rd: RD_WALK, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_WALK, nxt: UA_MEANW};
         UA_MEANW: w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_DIV, nxt: UA_OUT};
         UA_OUT:   w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_OUT,
                         cond: CND_OUT, nxt: UA_IDLE};
         default:  w = '{rd: RD_NONE, upd: 1'b0, div: DIV_NONE, cap: CAP_NONE,
                         cond: CND_GO, nxt: UA_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/ftws_div.sv
module ftws_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ftws_pkg::DIV_W-1:0] dividend,
   input  logic [ftws_pkg::DVS_W-1:0] divisor,
   output logic                      busy,
   output logic [ftws_pkg::DIV_W-1:0] quotient
);
   import ftws_pkg::*;

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      ge     = (trial >= {1'b0, dvs_ff});
      diff   = trial - {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = DCNT_W'(DIV_STEPS);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// Divide by ten: multiply by the reciprocal 0xCCCCCCCCD / 2^39, low half of
// the constant first, then the high half, on one 36x18 multiplier.
module ftws_div10 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ftws_pkg::DIV_W-1:0] dividend,
   output logic                       busy,
   output logic [ftws_pkg::SQ_W-1:0]  quotient
);
   import ftws_pkg::*;

   localparam int PART_W = DIV_W + D10_W;

   logic [1:0]        step_ff, step_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [D10_W-1:0]  mul_k;
   logic [PART_W-1:0] part;
   logic              first;

   assign busy     = (step_ff != 2'd0);
   assign quotient = acc_ff[D10_SHIFT +: SQ_W];
   assign first    = (step_ff == 2'(D10_STEPS));

   always_comb begin
      mul_k   = first ? D10_MUL_LO : D10_MUL_HI;
      part    = PART_W'(num_ff) * PART_W'(mul_k);
      step_in = step_ff;
      num_in  = num_ff;
      acc_in  = acc_ff;
      if (start) begin
         step_in = 2'(D10_STEPS);
         num_in  = dividend;
         acc_in  = '0;
      end else if (busy) begin
         step_in = step_ff - 1'b1;
         if (first) begin
            acc_in = PROD_W'(part);
         end else begin
            acc_in = acc_ff + (PROD_W'(part) << D10_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      num_ff <= num_in;
      acc_ff <= acc_in;
   end

endmodule

// File: rtl/ftws_win.sv
module ftws_win #(
   parameter int HISTORY_DEPTH = 128,
   parameter int CW            = $clog2(HISTORY_DEPTH + 1),
   parameter int SW            = 24 + $clog2(HISTORY_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ftws_pkg::SMP_W-1:0]  sample,
   input  ftws_pkg::rd_sel_type        rd,
   input  logic                        upd,
   output logic                        walk_more,
   output logic [ftws_pkg::SMP_W-1:0]  lo,
   output logic [ftws_pkg::SMP_W-1:0]  hi,
   output logic [SW-1:0]               sum,
   output logic [CW-1:0]               count
);
   import ftws_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);

   logic [SMP_W-1:0] ring_mem [HISTORY_DEPTH];
   logic [SMP_W-1:0] rdata_ff;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             cmp_ff, cmp_in;
   logic [SMP_W-1:0] lo_ff, lo_in;
   logic [SMP_W-1:0] hi_ff, hi_in;
   logic             full;
   logic             walk_rd;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [SMP_W-1:0] evict;

   assign full      = (count_ff == FULL_CNT);
   assign walk_more = (idx_ff != count_ff);
   assign walk_rd   = (rd == RD_WALK) && walk_more;
   assign rd_en     = (rd == RD_SLOT) || walk_rd;
   assign rd_addr   = (rd == RD_SLOT) ? slot_ff : idx_ff[AW-1:0];
   assign evict     = full ? rdata_ff : '0;
   assign lo        = lo_ff;
   assign hi        = hi_ff;
   assign sum       = sum_ff;
   assign count     = count_ff;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cmp_in   = walk_rd;
      if (upd) begin
         slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         count_in = full ? count_ff : count_ff + 1'b1;
         sum_in   = sum_ff - SW'(evict) + SW'(sample);
         idx_in   = '0;
         lo_in    = sample;
         hi_in    = sample;
      end else begin
         if (walk_rd) begin
            idx_in = idx_ff + 1'b1;
         end
         if (cmp_ff) begin
            if (rdata_ff < lo_ff) begin
               lo_in = rdata_ff;
            end
            if (rdata_ff > hi_ff) begin
               hi_in = rdata_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         ring_mem[slot_ff] <= sample;
      end
      if (rd_en) begin
         rdata_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         cmp_ff   <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         cmp_ff   <= cmp_in;
      end
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

endmodule

// File: rtl/ftws_seq.sv
module ftws_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ftws_pkg::seq_stat_type stat,
   output ftws_pkg::uword_type    uw,
   output logic                   idle
);
   import ftws_pkg::*;

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             hold;

   assign uw   = ucode(upc_ff);
   assign idle = (uw.cond == CND_REQ);

   always_comb begin
      case (uw.cond)
         CND_GO:   hold = 1'b0;
         CND_REQ:  hold = !stat.req_fire;
         CND_DIV:  hold = stat.div_busy;
         CND_WALK: hold = stat.walk_more;
         CND_OUT:  hold = !stat.out_free;
         default:  hold = 1'b0;
      endcase
      upc_in = hold ? upc_ff : uw.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: rtl/frame_time_window_stats.sv
// Frame-time statistics: each accepted item is one frame duration in
// microseconds. It enters a ring of the last HISTORY_DEPTH samples, updates a
// 1/10 exponential average (Q24.8, starts at zero), and yields one result
// with the average, 1e6/average in Q8 frames per second (0 for a zero
// average, saturated to 28 bits), and min, max and truncated mean of the held
// samples including the new one. A short microprogram runs each item: the
// divide by ten of the average update as a reciprocal multiply, two
// divisions (rate and mean) on one restoring divider at one quotient bit
// per cycle, and a walk over the held samples through the single ring read
// port, one sample per cycle, overlapped with the mean division. The time
// from one accepted item to the next grows with the number of held samples
// once the walk outlasts the mean division, and with any stall of the
// result channel. The next item is taken as soon as the result is loaded in
// the output register; a result not yet taken holds back only the following
// result.
module frame_time_window_stats #(
   parameter int HISTORY_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_frame_time_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_smoothed_time_us,
   output logic [27:0] rsp_smoothed_rate_q8,
   output logic [23:0] rsp_window_min_us,
   output logic [23:0] rsp_window_max_us,
   output logic [23:0] rsp_window_mean_us
);
   import ftws_pkg::*;

   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = SMP_W + CW;

   uword_type         uw;
   seq_stat_type      stat;
   logic              idle;
   logic              req_fire;
   logic              out_free;
   logic              div_busy;
   logic              div_start;
   logic [DIV_W-1:0]  div_num;
   logic [DVS_W-1:0]  div_den;
   logic [DIV_W-1:0]  quo;
   logic              ema_busy;
   logic              ema_start;
   logic [SQ_W-1:0]   ema_quo;
   logic              walk_more;
   logic [SMP_W-1:0]  lo;
   logic [SMP_W-1:0]  hi;
   logic [SW-1:0]     sum;
   logic [CW-1:0]     count;
   logic [DIV_W-1:0]  ema_num;
   logic [RATE_W-1:0] rate_sat;
   logic              out_load;

   logic [SMP_W-1:0]  x_ff, x_in;
   logic [SQ_W-1:0]   s_ff, s_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]  time_ff, time_in;
   logic [RATE_W-1:0] orate_ff, orate_in;
   logic [SMP_W-1:0]  min_ff, min_in;
   logic [SMP_W-1:0]  max_ff, max_in;
   logic [SMP_W-1:0]  mean_ff, mean_in;

   assign req_ready = idle;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (uw.cap == CAP_OUT) && out_free;

   assign stat = '{req_fire: req_fire, div_busy: div_busy || ema_busy,
                   walk_more: walk_more, out_free: out_free};

   ftws_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .uw    (uw),
      .idle  (idle)
   );

   ftws_win #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .CW            (CW),
      .SW            (SW)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .sample    (x_ff),
      .rd        (uw.rd),
      .upd       (uw.upd),
      .walk_more (walk_more),
      .lo        (lo),
      .hi        (hi),
      .sum       (sum),
      .count     (count)
   );

   ftws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (quo)
   );

   ftws_div10 u_div10 (
      .clock    (clock),
      .reset    (reset),
      .start    (ema_start),
      .dividend (ema_num),
      .busy     (ema_busy),
      .quotient (ema_quo)
   );

   always_comb begin
      ema_num   = (DIV_W'(s_ff) << 3) + DIV_W'(s_ff) + (DIV_W'(x_ff) << 8);
      ema_start = (uw.div == DIV_EMA);
      div_start = uw.div inside {DIV_RATE, DIV_MEAN};
      case (uw.div)
         DIV_RATE: begin
            div_num = RATE_NUM;
            div_den = ema_quo;
         end
         DIV_MEAN: begin
            div_num = DIV_W'(sum);
            div_den = DVS_W'(count);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   always_comb begin
      rate_sat = (quo > DIV_W'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
      x_in     = req_fire ? req_frame_time_us : x_ff;
      s_in     = (uw.cap == CAP_EMA) ? ema_quo : s_ff;
      rate_in  = rate_ff;
      if (uw.cap == CAP_RATE) begin
         rate_in = (s_ff == '0) ? '0 : rate_sat;
      end
      rsp_valid_in = rsp_valid_ff;
      time_in      = time_ff;
      orate_in     = orate_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         time_in      = s_ff[SQ_W-1:8];
         orate_in     = rate_ff;
         min_in       = lo;
         max_in       = hi;
         mean_in      = quo[SMP_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff     <= x_in;
      rate_ff  <= rate_in;
      time_ff  <= time_in;
      orate_ff <= orate_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      mean_ff  <= mean_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_smoothed_time_us = time_ff;
   assign rsp_smoothed_rate_q8 = orate_ff;
   assign rsp_window_min_us    = min_ff;
   assign rsp_window_max_us    = max_ff;
   assign rsp_window_mean_us   = mean_ff;

endmodule

// File: rtl/ftws_chk.sv
module ftws_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [23:0] req_frame_time_us,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_smoothed_time_us,
   input logic [27:0] rsp_smoothed_rate_q8,
   input logic [23:0] rsp_window_min_us,
   input logic [23:0] rsp_window_max_us,
   input logic [23:0] rsp_window_mean_us
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_mean_us)
         && $stable(rsp_smoothed_rate_q8))
      else $error("result dropped or changed while stalled");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_min_us <= rsp_window_mean_us)
         && (rsp_window_mean_us <= rsp_window_max_us))
      else $error("window mean outside min and max");

   a_rate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_smoothed_rate_q8 == 28'd0) |-> (rsp_smoothed_time_us == 24'd0))
      else $error("zero rate with a nonzero average");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item still in work");

endmodule

bind frame_time_window_stats ftws_chk u_ftws_chk (.*);

// File: dv/tb.sv
module tb;

   localparam int HIST_DEPTH = 128;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_TAIL = 150;
   localparam int LONG_HOLD = 1500;
   localparam int LONG_HOLD_AT = 700;
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT = 3000000;
   localparam longint unsigned RATE_NUMER = 64'd65536000000;
   localparam longint unsigned RATE_SAT = 64'd268435455;
   localparam logic [23:0] EDGE_FRAMES [20] = '{
      24'd0, 24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
      24'hAAAAAA, 24'h555555, 24'd1, 24'd0, 24'd16666, 24'd16667, 24'd33333,
      24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFE, 24'd0
   };

   typedef struct packed {
      logic [23:0] avg_us;
      logic [27:0] rate_q8;
      logic [23:0] min_us;
      logic [23:0] max_us;
      logic [23:0] mean_us;
   } frame_stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_frame_time_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_smoothed_time_us;
   logic [27:0] rsp_smoothed_rate_q8;
   logic [23:0] rsp_window_min_us;
   logic [23:0] rsp_window_max_us;
   logic [23:0] rsp_window_mean_us;

   logic [23:0]     frame_times_pending [$];
   frame_stats_type stats_due [$];
   int              total_items = 0;
   int              frames_accepted = 0;
   int              results_checked = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   int              gap_left = 0;
   int              hold_left = 0;
   logic            long_hold_done = 1'b0;

   logic [23:0]     hist_ring [HIST_DEPTH];
   int unsigned     hist_slot = 0;
   int unsigned     hist_count = 0;
   longint unsigned hist_sum = 0;
   logic [31:0]     ema_q8 = '0;

   frame_time_window_stats #(.HISTORY_DEPTH(HIST_DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frame_time_us(req_frame_time_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_smoothed_time_us(rsp_smoothed_time_us),
      .rsp_smoothed_rate_q8(rsp_smoothed_rate_q8),
      .rsp_window_min_us(rsp_window_min_us),
      .rsp_window_max_us(rsp_window_max_us),
      .rsp_window_mean_us(rsp_window_mean_us)
   );

   always #1 clock = ~clock;

   function automatic frame_stats_type advance_frame_stats(input logic [23:0] x);
      frame_stats_type r;
      longint unsigned ema_next;
      longint unsigned rate;
      longint unsigned mean;
      logic [23:0]     lo;
      logic [23:0]     hi;
      int unsigned     i;
      if (hist_count >= HIST_DEPTH) begin
         hist_sum = hist_sum - hist_ring[hist_slot];
      end else begin
         hist_count = hist_count + 1;
      end
      hist_ring[hist_slot] = x;
      hist_sum = hist_sum + x;
      hist_slot = (hist_slot + 1) % HIST_DEPTH;
      ema_next = (64'(ema_q8) * 9 + 64'(x) * 256) / 10;
      ema_q8 = ema_next[31:0];
      if (ema_q8 == 0) begin
         rate = 0;
      end else begin
         rate = RATE_NUMER / ema_q8;
         if (rate > RATE_SAT) rate = RATE_SAT;
      end
      lo = x;
      hi = x;
      for (i = 0; i < hist_count; i++) begin
         if (hist_ring[i] < lo) lo = hist_ring[i];
         if (hist_ring[i] > hi) hi = hist_ring[i];
      end
      mean = hist_sum / hist_count;
      r.avg_us = ema_q8[31:8];
      r.rate_q8 = rate[27:0];
      r.min_us = lo;
      r.max_us = hi;
      r.mean_us = mean[23:0];
      return r;
   endfunction

   function automatic int idle_pct(input int n, input int salt);
      if (n >= total_items - QUIET_TAIL) return 0;
      case ((n / 160 + salt) % 4)
         0: return 0;
         1: return 4;
         2: return 25;
         default: return 70;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            stats_due.insert(stats_due.size(), advance_frame_stats(req_frame_time_us));
            frames_accepted <= frames_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (frame_times_pending.size() != 0 &&
                         $urandom_range(0, 99) < idle_pct(frames_accepted, 0)) begin
               req_valid <= 1'b0;
               gap_left <= $urandom_range(0, 17);
            end else if (frame_times_pending.size() != 0) begin
               req_valid <= 1'b1;
               req_frame_time_us <= frame_times_pending[0];
               frame_times_pending.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && results_checked == LONG_HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD - 1;
         long_hold_done <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct(results_checked, 2)) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked <= results_checked + 1;
         if (stats_due.size() == 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            want = stats_due[0];
            stats_due.delete(0);
            if (rsp_smoothed_time_us !== want.avg_us || rsp_smoothed_rate_q8 !== want.rate_q8 ||
                rsp_window_min_us !== want.min_us || rsp_window_max_us !== want.max_us ||
                rsp_window_mean_us !== want.mean_us) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) begin
                  $display("result %0d mismatch (exp/got): avg %0d/%0d rate %0d/%0d",
                           results_checked, want.avg_us, rsp_smoothed_time_us,
                           want.rate_q8, rsp_smoothed_rate_q8);
                  $display("   min %0d/%0d max %0d/%0d mean %0d/%0d",
                           want.min_us, rsp_window_min_us, want.max_us, rsp_window_max_us,
                           want.mean_us, rsp_window_mean_us);
               end
            end
         end
      end
   end

   initial begin
      int          mode;
      int          len;
      int          k;
      int          n;
      logic [23:0] v;
      logic [23:0] base;
      foreach (EDGE_FRAMES[i]) begin
         frame_times_pending.insert(frame_times_pending.size(), EDGE_FRAMES[i]);
      end
      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 15);
         len = (mode == 10) ? $urandom_range(1, 260) : $urandom_range(1, 64);
         base = 24'($urandom_range(4000, 70000));
         for (k = 0; k < len && n < RANDOM_ITEMS; k++) begin
            case (mode)
               8, 14, 15: v = 24'($urandom);
               9:  v = 24'($urandom_range(0, 300));
               10: v = '0;
               11: v = 24'hFFFFFF - 24'($urandom_range(0, 15));
               12: v = ($urandom_range(0, 9) == 0) ?
                       24'($urandom_range(1000000, 24'hFFFFFF)) : base;
               13: v = 24'd1 << $urandom_range(0, 23);
               default: v = base + 24'($urandom_range(0, base / 8));
            endcase
            frame_times_pending.insert(frame_times_pending.size(), v);
            n++;
         end
      end
      total_items = frame_times_pending.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (frames_accepted != total_items || stats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
